// ----- hw/rtl/clt_pkg.sv -----
package clt_pkg;

  // Result event codes
  localparam logic [1:0] EV_BYTE = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_DONE = 2'd2;
  localparam logic [1:0] EV_ERR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MANY     = 3'd1;
  localparam logic [2:0] ERR_NO_NUM   = 3'd2;
  localparam logic [2:0] ERR_RANGE    = 3'd3;
  localparam logic [2:0] ERR_ESC_END  = 3'd4;
  localparam logic [2:0] ERR_QUOTE    = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW = 3'd6;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [4:0] DIGIT_NONE = 5'd31;
  localparam int unsigned SLOTS  = 4;
  localparam int unsigned QDEPTH = 4;

  // Scanner modes, one-hot
  typedef enum logic [7:0] {
    M_NORMAL = 8'b0000_0001,
    M_ESCAPE = 8'b0000_0010,
    M_START  = 8'b0000_0100,
    M_SIGNED = 8'b0000_1000,
    M_ZERO   = 8'b0001_0000,
    M_PFX_LO = 8'b0010_0000,
    M_PFX_UP = 8'b0100_0000,
    M_DIGITS = 8'b1000_0000
  } mode_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_e;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  out_byte;
    logic [3:0]  arg_index;
    logic [10:0] arg_length;
    logic [4:0]  arg_count;
    logic [2:0]  error_code;
  } res_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [2:0]            num;
    res_t [SLOTS-1:0]      res;
  } bundle_t;

  function automatic res_t mk_res(logic [1:0] ev, logic [7:0] b, logic [3:0] idx,
                                  logic [10:0] len, logic [4:0] cnt, logic [2:0] code);
    res_t r;
    r.event_res  = ev;
    r.out_byte   = b;
    r.arg_index  = idx;
    r.arg_length = len;
    r.arg_count  = cnt;
    r.error_code = code;
    return r;
  endfunction

  // Value of a hex digit, DIGIT_NONE for anything else
  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) d = 5'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LF) d = 5'(c - CH_LA + 8'd10);
    else if (c >= CH_UA && c <= CH_UF) d = 5'(c - CH_UA + 8'd10);
    return d;
  endfunction

endpackage

// ----- hw/rtl/clt_if.sv -----
interface clt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  modport source (output valid, output byte_req, input ready);
  modport sink (input valid, input byte_req, output ready);
endinterface

interface clt_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  out_byte;
  logic [3:0]  arg_index;
  logic [10:0] arg_length;
  logic [4:0]  arg_count;
  logic [2:0]  error_code;
  logic        last;
  modport source (output valid, output event_res, output out_byte, output arg_index,
                  output arg_length, output arg_count, output error_code, output last,
                  input ready);
  modport sink (input valid, input event_res, input out_byte, input arg_index,
                input arg_length, input arg_count, input error_code, input last,
                output ready);
endinterface

// ----- hw/rtl/command_line_tokenizer_core.sv -----
// Channel | Dir | Payload                                            | Transfer
// in_i    | in  | byte_req                                           | valid && ready
// out_o   | out | event_res out_byte arg_index arg_length arg_count  | valid && ready
//         |     | error_code last                                    |
//
// A byte is scanned in the cycle it is taken; its results (up to four) enter a
// four-entry queue as one entry, and the back end sends them one result per cycle
// while out_o.ready is high. One byte per cycle in while the queue has room; a
// byte's results leave in order. in_i.ready drops only while the queue is full.
// Reset (async, active low) clears the scanner state and empties the queue.
module command_line_tokenizer_core import clt_pkg::*; #(
  parameter int unsigned MAX_ARGS     = 16,
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clt_byte_if.sink   in_i,
  clt_res_if.source  out_o
);

  logic    push, full, pop, empty;
  bundle_t push_data, head;

  clt_front #(
    .MAX_ARGS     (MAX_ARGS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (push_data)
  );

  clt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  clt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .data_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- hw/rtl/clt_front.sv -----
module clt_front import clt_pkg::*; #(
  parameter int unsigned MAX_ARGS     = 16,
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clt_byte_if.sink    in_i,
  input  logic        full_i,
  output logic        push_o,
  output bundle_t     bundle_o
);

  localparam int unsigned ArgW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int unsigned TotW = $clog2(BUFFER_BYTES + 1);
  localparam logic [TotW-1:0] BufLim = TotW'(BUFFER_BYTES);
  localparam logic [ArgW:0]   ArgLim = (ArgW + 1)'(MAX_ARGS);

  logic            quoted_q, quoted_d;
  mode_e           mode_q, mode_d;
  logic [8:0]      value_q, value_d;
  base_e           base_q, base_d;
  logic            neg_q, neg_d;
  logic            big_q, big_d;
  logic [ArgW-1:0] arg_q, arg_d;
  logic [TotW-1:0] len_q, len_d;
  logic [TotW-1:0] tot_q, tot_d;
  logic            failed_q, failed_d;
  logic            started_q, started_d;

  logic            accept;
  logic [7:0]      c;
  logic [4:0]      dig;
  logic [4:0]      base_val;
  logic [12:0]     acc;
  logic [2:0]      n;
  logic            err, clr, fin, px, pl;
  logic [7:0]      x_ch;
  logic [31:0]     arg_w, cnt_w, len_w;
  logic [ArgW:0]   arg_next;
  res_t [SLOTS-1:0] res;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign c          = in_i.byte_req;
  assign dig        = digit_of(c);

  always_comb begin
    case (base_q)
      BASE_OCT: base_val = 5'd8;
      BASE_HEX: base_val = 5'd16;
      default:  base_val = 5'd10;
    endcase
  end

  // value * base + digit, saturates at 256 below
  always_comb begin
    case (base_q)
      BASE_OCT: acc = {value_q, 3'b000} + 13'(dig);
      BASE_HEX: acc = 13'({value_q, 4'b0000}) + 13'(dig);
      default:  acc = 13'({value_q, 3'b000}) + 13'({value_q, 1'b0}) + 13'(dig);
    endcase
  end

  // One byte of the scanner, results collected into slots
  always_comb begin
    quoted_d  = quoted_q;
    mode_d    = mode_q;
    value_d   = value_q;
    base_d    = base_q;
    neg_d     = neg_q;
    big_d     = big_q;
    arg_d     = arg_q;
    len_d     = len_q;
    tot_d     = tot_q;
    failed_d  = failed_q;
    started_d = started_q;
    res       = '0;
    n         = 3'd0;
    err       = 1'b0;
    clr       = 1'b0;
    fin       = 1'b0;
    px        = 1'b0;
    pl        = 1'b0;
    x_ch      = (mode_q == M_PFX_LO) ? CH_LX : CH_UX;
    arg_w     = '0;
    cnt_w     = '0;
    len_w     = '0;
    arg_next  = '0;

    if (failed_q) begin
      if (c == CH_NUL) clr = 1'b1;
    end else begin
      if (c != CH_NUL) started_d = 1'b1;

      case (mode_q)
        M_ESCAPE: begin
          if (c == CH_NUL) begin
            res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_ESC_END);
            n = n + 3'd1;
            err = 1'b1;
            clr = 1'b1;
          end else begin
            mode_d = M_NORMAL;
            if (tot_d >= BufLim) begin
              res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_OVERFLOW);
              n = n + 3'd1;
              err = 1'b1;
              failed_d = 1'b1;
            end else begin
              arg_w = 32'(arg_d);
              res[n[1:0]] = mk_res(EV_BYTE, c, arg_w[3:0], '0, '0, ERR_NONE);
              n = n + 3'd1;
              tot_d = tot_d + 1'b1;
              len_d = len_d + 1'b1;
            end
          end
        end
        M_START, M_SIGNED: begin
          if (mode_q == M_START && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            mode_d = mode_q;
          end else if (mode_q == M_START && c == CH_PLUS) begin
            mode_d = M_SIGNED;
          end else if (mode_q == M_START && c == CH_MINUS) begin
            neg_d  = 1'b1;
            mode_d = M_SIGNED;
          end else if (c == CH_0) begin
            mode_d  = M_ZERO;
            value_d = '0;
            base_d  = BASE_OCT;
          end else if (c >= CH_1 && c <= CH_9) begin
            mode_d  = M_DIGITS;
            base_d  = BASE_DEC;
            value_d = 9'(dig);
          end else begin
            res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_NO_NUM);
            n = n + 3'd1;
            err = 1'b1;
            if (c == CH_NUL) clr = 1'b1;
            else failed_d = 1'b1;
          end
        end
        M_ZERO: begin
          if (c == CH_LX) mode_d = M_PFX_LO;
          else if (c == CH_UX) mode_d = M_PFX_UP;
          else if (c >= CH_0 && c <= CH_7) begin
            mode_d  = M_DIGITS;
            value_d = 9'(dig);
          end else begin
            fin = 1'b1;
            pl  = 1'b1;
          end
        end
        M_PFX_LO, M_PFX_UP: begin
          if (dig < 5'd16) begin
            mode_d  = M_DIGITS;
            base_d  = BASE_HEX;
            value_d = 9'(dig);
          end else begin
            fin = 1'b1;
            px  = 1'b1;
            pl  = 1'b1;
          end
        end
        M_DIGITS: begin
          if (dig < base_val) begin
            if (acc > 13'd255) begin
              big_d   = 1'b1;
              value_d = 9'd256;
            end else begin
              value_d = acc[8:0];
            end
          end else begin
            fin = 1'b1;
            pl  = 1'b1;
          end
        end
        default: pl = 1'b1;
      endcase

      // End of a number: range and overflow checks, then store it
      if (fin) begin
        mode_d = M_NORMAL;
        if (big_q || (neg_q && value_q != '0)) begin
          res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_RANGE);
          n = n + 3'd1;
          err = 1'b1;
          if (c == CH_NUL) clr = 1'b1;
          else failed_d = 1'b1;
        end else if (tot_d >= BufLim) begin
          res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_OVERFLOW);
          n = n + 3'd1;
          err = 1'b1;
          if (c == CH_NUL) clr = 1'b1;
          else failed_d = 1'b1;
        end else begin
          arg_w = 32'(arg_d);
          res[n[1:0]] = mk_res(EV_BYTE, value_q[7:0], arg_w[3:0], '0, '0, ERR_NONE);
          n = n + 3'd1;
          tot_d = tot_d + 1'b1;
          len_d = len_d + 1'b1;
        end
      end

      // Bare hex prefix: the x itself is data
      if (px && !err) begin
        if (tot_d >= BufLim) begin
          res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_OVERFLOW);
          n = n + 3'd1;
          err = 1'b1;
          if (c == CH_NUL) clr = 1'b1;
          else failed_d = 1'b1;
        end else begin
          arg_w = 32'(arg_d);
          res[n[1:0]] = mk_res(EV_BYTE, x_ch, arg_w[3:0], '0, '0, ERR_NONE);
          n = n + 3'd1;
          tot_d = tot_d + 1'b1;
          len_d = len_d + 1'b1;
        end
      end

      // Ordinary byte handling
      if (pl && !err) begin
        arg_w    = 32'(arg_d);
        len_w    = 32'(len_d);
        cnt_w    = 32'(arg_d) + 32'd1;
        arg_next = {1'b0, arg_d} + 1'b1;
        if (c == CH_NUL) begin
          if (quoted_d) begin
            res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_QUOTE);
            n = n + 3'd1;
            clr = 1'b1;
          end else if (!started_d) begin
            res[n[1:0]] = mk_res(EV_DONE, '0, '0, '0, '0, ERR_NONE);
            n = n + 3'd1;
            clr = 1'b1;
          end else if (tot_d >= BufLim) begin
            res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_OVERFLOW);
            n = n + 3'd1;
            clr = 1'b1;
          end else begin
            res[n[1:0]] = mk_res(EV_END, '0, arg_w[3:0], len_w[10:0], '0, ERR_NONE);
            n = n + 3'd1;
            res[n[1:0]] = mk_res(EV_DONE, '0, '0, '0, cnt_w[4:0], ERR_NONE);
            n = n + 3'd1;
            clr = 1'b1;
          end
        end else if (c == CH_SPACE && !quoted_d) begin
          if (tot_d >= BufLim) begin
            res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_OVERFLOW);
            n = n + 3'd1;
            failed_d = 1'b1;
          end else if (arg_next >= ArgLim) begin
            res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_MANY);
            n = n + 3'd1;
            failed_d = 1'b1;
          end else begin
            res[n[1:0]] = mk_res(EV_END, '0, arg_w[3:0], len_w[10:0], '0, ERR_NONE);
            n = n + 3'd1;
            tot_d = tot_d + 1'b1;
            arg_d = arg_next[ArgW-1:0];
            len_d = '0;
          end
        end else if (c == CH_SLASH) begin
          mode_d  = M_START;
          value_d = '0;
          base_d  = BASE_DEC;
          neg_d   = 1'b0;
          big_d   = 1'b0;
        end else if (c == CH_AT) begin
          mode_d = M_ESCAPE;
        end else if (c == CH_QUOTE) begin
          quoted_d = !quoted_d;
        end else if (tot_d >= BufLim) begin
          res[n[1:0]] = mk_res(EV_ERR, '0, '0, '0, '0, ERR_OVERFLOW);
          n = n + 3'd1;
          failed_d = 1'b1;
        end else begin
          res[n[1:0]] = mk_res(EV_BYTE, c, arg_w[3:0], '0, '0, ERR_NONE);
          n = n + 3'd1;
          tot_d = tot_d + 1'b1;
          len_d = len_d + 1'b1;
        end
      end
    end

    // Message state back to its initial values
    if (clr) begin
      quoted_d  = 1'b0;
      mode_d    = M_NORMAL;
      value_d   = '0;
      base_d    = BASE_DEC;
      neg_d     = 1'b0;
      big_d     = 1'b0;
      arg_d     = '0;
      len_d     = '0;
      tot_d     = '0;
      failed_d  = 1'b0;
      started_d = 1'b0;
    end
  end

  assign push_o       = accept && (n != 3'd0);
  assign bundle_o.num = n;
  assign bundle_o.res = res;

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      mode_q    <= M_NORMAL;
      value_q   <= '0;
      base_q    <= BASE_DEC;
      neg_q     <= 1'b0;
      big_q     <= 1'b0;
      arg_q     <= '0;
      len_q     <= '0;
      tot_q     <= '0;
      failed_q  <= 1'b0;
      started_q <= 1'b0;
    end else if (accept) begin
      quoted_q  <= quoted_d;
      mode_q    <= mode_d;
      value_q   <= value_d;
      base_q    <= base_d;
      neg_q     <= neg_d;
      big_q     <= big_d;
      arg_q     <= arg_d;
      len_q     <= len_d;
      tot_q     <= tot_d;
      failed_q  <= failed_d;
      started_q <= started_d;
    end
  end

endmodule

// ----- hw/rtl/clt_queue.sv -----
module clt_queue import clt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output bundle_t data_o
);

  localparam int unsigned PtrW = $clog2(QDEPTH);

  bundle_t           mem_q [QDEPTH];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

// ----- hw/rtl/clt_back.sv -----
module clt_back import clt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  bundle_t    data_i,
  output logic       pop_o,
  clt_res_if.source  out_o
);

  logic [1:0] sel_q, sel_d;
  logic       is_last;
  logic       xfer;
  res_t       cur;

  assign cur     = data_i.res[sel_q];
  assign is_last = ({1'b0, sel_q} + 3'd1) == data_i.num;
  assign xfer    = out_o.valid && out_o.ready;
  assign pop_o   = xfer && is_last;

  assign out_o.valid      = !empty_i;
  assign out_o.event_res  = cur.event_res;
  assign out_o.out_byte   = cur.out_byte;
  assign out_o.arg_index  = cur.arg_index;
  assign out_o.arg_length = cur.arg_length;
  assign out_o.arg_count  = cur.arg_count;
  assign out_o.error_code = cur.error_code;
  assign out_o.last       = is_last;

  // Walk the slots of the head entry
  always_comb begin
    sel_d = sel_q;
    if (xfer) sel_d = is_last ? 2'd0 : sel_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

// ----- test/tb_command_line_tokenizer_core.sv -----
module tb_command_line_tokenizer_core;
  import clt_pkg::*;

  localparam int unsigned ARG_LIMIT   = 16;
  localparam int unsigned BUF_PLACES  = 1024;
  localparam int unsigned RAND_ITEMS  = 380;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DIR_N       = 25;

  // One result as it appears on the output channel
  typedef struct packed {
    res_t r;
    logic last;
  } tok_res_t;

  // Directed stimulus row; results are typed in only where typed is set
  typedef struct packed {
    logic [7:0]  c;
    logic        typed;
    logic [2:0]  n;
    res_t [0:3]  r;
  } dir_row_t;

  localparam res_t NO_RES = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  clt_byte_if byte_if ();
  clt_res_if  res_if ();

  command_line_tokenizer_core #(
    .MAX_ARGS    (ARG_LIMIT),
    .BUFFER_BYTES(BUF_PLACES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (res_if)
  );

  always #10 clk_i = ~clk_i;

  // Scanner state kept by the tokenizer model
  logic        sc_quoted;
  mode_e       sc_mode;
  logic [8:0]  sc_val;
  base_e       sc_base;
  logic        sc_neg;
  logic        sc_big;
  logic [3:0]  sc_arg;
  logic [10:0] sc_len;
  logic [10:0] sc_total;
  logic        sc_failed;
  logic        sc_started;

  tok_res_t    step_res[$];
  bit          step_err;
  tok_res_t    pending_results[$];
  logic [7:0]  msg_q[$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle      = 1'b0;
  bit          hold_req     = 1'b0;

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------

  function automatic void clear_msg_state();
    sc_quoted  = 1'b0;
    sc_mode    = M_NORMAL;
    sc_val     = '0;
    sc_base    = BASE_DEC;
    sc_neg     = 1'b0;
    sc_big     = 1'b0;
    sc_arg     = '0;
    sc_len     = '0;
    sc_total   = '0;
    sc_failed  = 1'b0;
    sc_started = 1'b0;
  endfunction

  function automatic void push_res(logic [1:0] ev, logic [7:0] b, logic [3:0] idx,
                                   logic [10:0] len, logic [4:0] cnt, logic [2:0] code);
    tok_res_t t;
    t.r.event_res  = ev;
    t.r.out_byte   = b;
    t.r.arg_index  = idx;
    t.r.arg_length = len;
    t.r.arg_count  = cnt;
    t.r.error_code = code;
    t.last         = 1'b0;
    if (step_res.size() < 5) step_res.push_back(t);
  endfunction

  // A nul byte that errors clears the message; any other byte marks it failed
  function automatic void raise_error(logic [2:0] code, logic [7:0] c);
    push_res(EV_ERR, 8'h00, 4'd0, 11'd0, 5'd0, code);
    step_err = 1'b1;
    if (c == CH_NUL) clear_msg_state();
    else sc_failed = 1'b1;
  endfunction

  function automatic void store_byte(logic [7:0] b, logic [7:0] c);
    if (sc_total >= BUF_PLACES) begin
      raise_error(ERR_OVERFLOW, c);
      return;
    end
    push_res(EV_BYTE, b, sc_arg, 11'd0, 5'd0, ERR_NONE);
    sc_total++;
    sc_len++;
  endfunction

  function automatic void plain_byte(logic [7:0] c);
    if (c == CH_NUL) begin
      if (sc_quoted) raise_error(ERR_QUOTE, c);
      else if (!sc_started) begin
        push_res(EV_DONE, 8'h00, 4'd0, 11'd0, 5'd0, ERR_NONE);
        clear_msg_state();
      end else if (sc_total >= BUF_PLACES) raise_error(ERR_OVERFLOW, c);
      else begin
        push_res(EV_END, 8'h00, sc_arg, sc_len, 5'd0, ERR_NONE);
        push_res(EV_DONE, 8'h00, 4'd0, 11'd0, 5'({1'b0, sc_arg}) + 5'd1, ERR_NONE);
        clear_msg_state();
      end
    end else if (c == CH_SPACE && !sc_quoted) begin
      // overflow is checked before the argument limit
      if (sc_total >= BUF_PLACES) raise_error(ERR_OVERFLOW, c);
      else if (int'(sc_arg) + 1 >= ARG_LIMIT) raise_error(ERR_MANY, c);
      else begin
        push_res(EV_END, 8'h00, sc_arg, sc_len, 5'd0, ERR_NONE);
        sc_total++;
        sc_arg++;
        sc_len = '0;
      end
    end else if (c == CH_SLASH) begin
      sc_mode = M_START;
      sc_val  = '0;
      sc_base = BASE_DEC;
      sc_neg  = 1'b0;
      sc_big  = 1'b0;
    end else if (c == CH_AT) begin
      sc_mode = M_ESCAPE;
    end else if (c == CH_QUOTE) begin
      sc_quoted = ~sc_quoted;
    end else begin
      store_byte(c, c);
    end
  endfunction

  function automatic int unsigned digit_val(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return 99;
  endfunction

  function automatic int unsigned radix();
    case (sc_base)
      BASE_OCT: return 8;
      BASE_HEX: return 16;
      default:  return 10;
    endcase
  endfunction

  // Saturate at 256 so that any out-of-range magnitude stays out of range
  function automatic void add_digit(int unsigned d);
    int unsigned v;
    v = int'(sc_val) * radix() + d;
    if (v > 255) begin
      sc_big = 1'b1;
      v = 256;
    end
    sc_val = 9'(v);
  endfunction

  function automatic void end_number(logic [7:0] c);
    sc_mode = M_NORMAL;
    if (sc_big || (sc_neg && sc_val != 0)) raise_error(ERR_RANGE, c);
    else store_byte(sc_val[7:0], c);
  endfunction

  function automatic void begin_digits(logic [7:0] c);
    if (c == CH_0) begin
      sc_mode = M_ZERO;
      sc_val  = '0;
      sc_base = BASE_OCT;
    end else if (c >= CH_1 && c <= CH_9) begin
      sc_mode = M_DIGITS;
      sc_base = BASE_DEC;
      sc_val  = 9'(c - CH_0);
    end else begin
      raise_error(ERR_NO_NUM, c);
    end
  endfunction

  // Returns 1 when the byte is dropped because the message already failed
  function automatic bit tokenize_byte(logic [7:0] c);
    int unsigned d;
    logic [7:0]  x;
    step_res.delete();
    step_err = 1'b0;
    if (sc_failed) begin
      if (c == CH_NUL) clear_msg_state();
      return 1'b1;
    end
    if (c != CH_NUL) sc_started = 1'b1;
    case (sc_mode)
      M_ESCAPE: begin
        if (c == CH_NUL) raise_error(ERR_ESC_END, c);
        else begin
          sc_mode = M_NORMAL;
          store_byte(c, c);
        end
      end
      M_START: begin
        // whitespace before the number is skipped
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) ;
        else if (c == CH_PLUS) sc_mode = M_SIGNED;
        else if (c == CH_MINUS) begin
          sc_neg  = 1'b1;
          sc_mode = M_SIGNED;
        end else begin_digits(c);
      end
      M_SIGNED: begin_digits(c);
      M_ZERO: begin
        if (c == CH_LX) sc_mode = M_PFX_LO;
        else if (c == CH_UX) sc_mode = M_PFX_UP;
        else if (c >= CH_0 && c <= CH_7) begin
          sc_mode = M_DIGITS;
          add_digit(int'(c - CH_0));
        end else begin
          end_number(c);
          if (!step_err) plain_byte(c);
        end
      end
      M_PFX_LO, M_PFX_UP: begin
        d = digit_val(c);
        if (d < 16) begin
          sc_mode = M_DIGITS;
          sc_base = BASE_HEX;
          sc_val  = '0;
          add_digit(d);
        end else begin
          // bare prefix: zero, then the x itself, then this byte
          x = (sc_mode == M_PFX_LO) ? CH_LX : CH_UX;
          end_number(c);
          if (!step_err) store_byte(x, c);
          if (!step_err) plain_byte(c);
        end
      end
      M_DIGITS: begin
        d = digit_val(c);
        if (d < radix()) add_digit(d);
        else begin
          end_number(c);
          if (!step_err) plain_byte(c);
        end
      end
      default: plain_byte(c);
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic cmp_field(string name, logic [10:0] got, logic [10:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  task automatic check_result();
    tok_res_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected (event %0d)",
                                results_seen, res_if.event_res));
      return;
    end
    want = pending_results.pop_front();
    cmp_field("event_res",  11'(res_if.event_res),  11'(want.r.event_res));
    cmp_field("out_byte",   11'(res_if.out_byte),   11'(want.r.out_byte));
    cmp_field("arg_index",  11'(res_if.arg_index),  11'(want.r.arg_index));
    cmp_field("arg_length", res_if.arg_length,      want.r.arg_length);
    cmp_field("arg_count",  11'(res_if.arg_count),  11'(want.r.arg_count));
    cmp_field("error_code", 11'(res_if.error_code), 11'(want.r.error_code));
    cmp_field("last",       11'(res_if.last),       11'(want.last));
  endtask

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------

  task automatic feed_byte(input logic [7:0] c, input bit use_pred, output bit ignored);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid    <= 1'b1;
    byte_if.byte_req <= c;
    do @(posedge clk_i); while (!(byte_if.valid === 1'b1 && byte_if.ready === 1'b1));
    ignored = tokenize_byte(c);
    if (use_pred) foreach (step_res[i]) pending_results.push_back(step_res[i]);
  endtask

  function automatic logic [7:0] rand_text();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  // '/' and a number in strtol base-0 form, mostly in range
  task automatic push_number();
    int unsigned v, sgn;
    string       s;
    bit          upper;
    logic [7:0]  ch;
    msg_q.push_back(CH_SLASH);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2))
        msg_q.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
    sgn = $urandom_range(0, 7);
    if (sgn == 0) msg_q.push_back(CH_PLUS);
    if (sgn == 1) msg_q.push_back(CH_MINUS);
    v = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 4095) : $urandom_range(0, 255);
    if (sgn == 1 && $urandom_range(0, 1) == 1) v = 0;
    upper = $urandom_range(0, 1);
    case ($urandom_range(0, 5))
      0, 1, 2: s = $sformatf("%0d", v);
      3:       s = {"0", $sformatf("%0o", v)};
      4:       s = {upper ? "0X" : "0x", $sformatf("%0h", v)};
      default: begin
        case ($urandom_range(0, 3))
          0:       s = upper ? "0X" : "0x";
          1:       s = "0";
          2:       s = "q";
          default: s = "08";
        endcase
      end
    endcase
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (upper && ch >= CH_LA && ch <= CH_LF) ch = ch - 8'h20;
      msg_q.push_back(ch);
    end
  endtask

  // One message of random tokens, mostly well formed, ended by a nul byte
  task automatic build_msg();
    int unsigned many;
    if ($urandom_range(0, 14) == 0) begin
      // argument count around the limit
      many = $urandom_range(14, 17);
      repeat (many) begin
        msg_q.push_back(rand_text());
        msg_q.push_back(CH_SPACE);
      end
    end else begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: repeat ($urandom_range(1, 4)) msg_q.push_back(rand_text());
          3:       msg_q.push_back(CH_SPACE);
          4: begin
            msg_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 3))
              msg_q.push_back($urandom_range(0, 2) == 0 ? CH_SPACE : rand_text());
            if ($urandom_range(0, 5) != 0) msg_q.push_back(CH_QUOTE);
          end
          5: begin
            msg_q.push_back(CH_AT);
            msg_q.push_back(8'($urandom_range(1, 255)));
          end
          6, 7:    push_number();
          8:       msg_q.push_back(8'($urandom_range(1, 255)));
          default: repeat ($urandom_range(1, 6)) msg_q.push_back(CH_SPACE);
        endcase
      end
      // dangling escape, slash or quote right before the end
      case ($urandom_range(0, 11))
        0:       msg_q.push_back(CH_AT);
        1:       msg_q.push_back(CH_SLASH);
        2:       msg_q.push_back(CH_QUOTE);
        default: ;
      endcase
    end
    msg_q.push_back(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stim
    dir_row_t    dir_tab [DIR_N];
    tok_res_t    want;
    bit          ignored;
    int unsigned rand_items;
    bit          hold_done;

    dir_tab = '{
      '{CH_NUL,   1'b1, 3'd1,
        '{mk_res(EV_DONE, 8'h00, 4'd0, 11'd0, 5'd0, ERR_NONE), NO_RES, NO_RES, NO_RES}},
      '{8'hff,    1'b1, 3'd1,
        '{mk_res(EV_BYTE, 8'hff, 4'd0, 11'd0, 5'd0, ERR_NONE), NO_RES, NO_RES, NO_RES}},
      '{8'h01,    1'b1, 3'd1,
        '{mk_res(EV_BYTE, 8'h01, 4'd0, 11'd0, 5'd0, ERR_NONE), NO_RES, NO_RES, NO_RES}},
      '{CH_NUL,   1'b1, 3'd2,
        '{mk_res(EV_END, 8'h00, 4'd0, 11'd2, 5'd0, ERR_NONE),
          mk_res(EV_DONE, 8'h00, 4'd0, 11'd0, 5'd1, ERR_NONE), NO_RES, NO_RES}},
      // escape right before the end
      '{CH_AT,    1'b1, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_NUL,   1'b1, 3'd1,
        '{mk_res(EV_ERR, 8'h00, 4'd0, 11'd0, 5'd0, ERR_ESC_END), NO_RES, NO_RES, NO_RES}},
      // quote left open
      '{CH_QUOTE, 1'b1, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_NUL,   1'b1, 3'd1,
        '{mk_res(EV_ERR, 8'h00, 4'd0, 11'd0, 5'd0, ERR_QUOTE), NO_RES, NO_RES, NO_RES}},
      // slash without a number, then the failed message is dropped
      '{CH_SLASH, 1'b1, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{8'h7a,    1'b1, 3'd1,
        '{mk_res(EV_ERR, 8'h00, 4'd0, 11'd0, 5'd0, ERR_NO_NUM), NO_RES, NO_RES, NO_RES}},
      '{CH_NUL,   1'b1, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      // negative number
      '{CH_SLASH, 1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_MINUS, 1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_1,     1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_NUL,   1'b1, 3'd1,
        '{mk_res(EV_ERR, 8'h00, 4'd0, 11'd0, 5'd0, ERR_RANGE), NO_RES, NO_RES, NO_RES}},
      // bare hex prefix closed by the end of the message
      '{CH_SLASH, 1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_0,     1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_LX,    1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_NUL,   1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      // octal number closed by a space, then an empty last argument
      '{CH_SLASH, 1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_0,     1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_7,     1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_7,     1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_SPACE, 1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}},
      '{CH_NUL,   1'b0, 3'd0, '{NO_RES, NO_RES, NO_RES, NO_RES}}
    };

    rst_ni           <= 1'b0;
    byte_if.valid    <= 1'b0;
    byte_if.byte_req <= 8'h00;
    clear_msg_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_tab[i]) begin
      feed_byte(dir_tab[i].c, !dir_tab[i].typed, ignored);
      if (dir_tab[i].typed)
        for (int k = 0; k < dir_tab[i].n; k++) begin
          want.r    = dir_tab[i].r[k];
          want.last = (k == dir_tab[i].n - 1);
          pending_results.push_back(want);
        end
    end

    // source pauses until the output side has drained
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);

    // random messages
    rand_items = 0;
    hold_done  = 1'b0;
    while (rand_items < RAND_ITEMS) begin
      msg_q.delete();
      build_msg();
      foreach (msg_q[i]) begin
        feed_byte(msg_q[i], 1'b1, ignored);
        if (!ignored) rand_items++;
        // long sink hold while bytes keep coming
        if (!hold_done && rand_items >= 150) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        no_idle = (rand_items >= 250 && rand_items < 320);
      end
    end

    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_command_line_tokenizer_core: PASS");
    end else begin
      $display("tb_command_line_tokenizer_core: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink
  // ---------------------------------------------------------------------------

  initial begin : sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
      check_result();
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_command_line_tokenizer_core: FAIL");
          $finish;
        end
      end
    end
  end

endmodule
